/* rtl/fdcbf_pkg.sv */
package fdcbf_pkg;

    // default panel width in columns
    localparam int C_COLUMNS = 28;

    localparam int C_WORD_W  = 7;
    localparam int C_BYTE_W  = 8;
    localparam int C_WIDTH_W = 5;
    localparam int C_HEIGHT_W = 3;

    // frame bytes
    localparam logic [7:0] C_BYTE_SOF  = 8'h80;
    localparam logic [7:0] C_BYTE_CMD  = 8'h83;
    localparam logic [7:0] C_BYTE_ADDR = 8'hFF;
    localparam logic [7:0] C_BYTE_EOF  = 8'h8F;
    localparam logic [6:0] C_INV_MASK  = 7'h7F;

    // register indexes on the config port
    localparam logic [1:0] C_REG_WIDTH  = 2'd0;
    localparam logic [1:0] C_REG_HEIGHT = 2'd1;
    localparam logic [1:0] C_REG_INVERT = 2'd2;

    // request kinds
    localparam logic C_REQ_PIXEL = 1'b0;
    localparam logic C_REQ_SEND  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SOF,
        S_CMD,
        S_ADDR,
        S_COL,
        S_EOF
    } t_state;

    typedef enum logic [2:0] {
        B_SOF,
        B_CMD,
        B_ADDR,
        B_COL,
        B_EOF
    } t_bsel;

    typedef struct packed {
        logic  in_ready;
        logic  pix_we;
        logic  rd_en;
        logic  cnt_clr;
        logic  cnt_inc;
        logic  load;
        t_bsel sel;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic req_send;
        logic out_free;
        logic last_col;
    } t_sts;

endpackage

/* rtl/flipdot_column_buffer_framer_top.sv */
// writes: a pixel write lands in the store at its accept edge; a send's first byte is
// loaded from S_SOF. throughput: one pixel write per cycle while idle; a send holds the input
// for its accept plus COLUMNS+4 byte loads, one per cycle while the sink keeps tready high,
// so that no later pixel write can change a frame still going out
// reset: synchronous active-low; column store reads as all zeros through per-column
// valid flags, config returns to width 28, height 7, invert off
module flipdot_column_buffer_framer_top #(
    parameter int COLUMNS = fdcbf_pkg::C_COLUMNS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // pixel_x[7:0], pixel_y[15:8], pixel_on[16], zero pad
    input  logic        s_axis_tuser,  // req_type: 0 pixel write, 1 send frame

    // frame byte stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // tx_byte[7:0]
    output logic        m_axis_tlast,  // frame_end

    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // config registers
    logic [fdcbf_pkg::C_WIDTH_W-1:0]  r_width;
    logic [fdcbf_pkg::C_HEIGHT_W-1:0] r_height;
    logic                             r_invert;
    logic                             cfg_wr;
    logic [1:0]                       cfg_idx;

    // controller <-> datapath
    fdcbf_pkg::t_cmd cmd;
    fdcbf_pkg::t_sts sts;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 5'd28;
            r_height <= 3'd7;
            r_invert <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                fdcbf_pkg::C_REG_WIDTH:  r_width  <= pwdata[fdcbf_pkg::C_WIDTH_W-1:0];
                fdcbf_pkg::C_REG_HEIGHT: r_height <= pwdata[fdcbf_pkg::C_HEIGHT_W-1:0];
                fdcbf_pkg::C_REG_INVERT: r_invert <= pwdata[0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    // read back, unmapped reads as zero
    always_comb begin
        case (cfg_idx)
            fdcbf_pkg::C_REG_WIDTH:  prdata = {27'd0, r_width};
            fdcbf_pkg::C_REG_HEIGHT: prdata = {29'd0, r_height};
            fdcbf_pkg::C_REG_INVERT: prdata = {31'd0, r_invert};
            default:                 prdata = 32'd0;
        endcase
    end

    // sequencer: idle / header bytes / column sweep / closing byte
    fdcbf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // column store, read prefetch and output register
    fdcbf_dp #(
        .COLUMNS (COLUMNS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_valid  (s_axis_tvalid),
        .i_req_type  (s_axis_tuser),
        .i_pixel_x   (s_axis_tdata[7:0]),
        .i_pixel_y   (s_axis_tdata[15:8]),
        .i_pixel_on  (s_axis_tdata[16]),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_invert    (r_invert),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_tx_byte   (m_axis_tdata),
        .o_frame_end (m_axis_tlast)
    );

    // input is taken only while the sequencer is idle
    assign s_axis_tready = cmd.in_ready;

endmodule

/* rtl/fdcbf_ctrl.sv */
module fdcbf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fdcbf_pkg::t_sts  i_sts,
    output fdcbf_pkg::t_cmd  o_cmd
);

    fdcbf_pkg::t_state r_state;
    fdcbf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fdcbf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fdcbf_pkg::S_IDLE: begin
                if (i_sts.in_valid && i_sts.req_send) n_state = fdcbf_pkg::S_SOF;
            end
            fdcbf_pkg::S_SOF: begin
                if (i_sts.out_free) n_state = fdcbf_pkg::S_CMD;
            end
            fdcbf_pkg::S_CMD: begin
                if (i_sts.out_free) n_state = fdcbf_pkg::S_ADDR;
            end
            fdcbf_pkg::S_ADDR: begin
                if (i_sts.out_free) n_state = fdcbf_pkg::S_COL;
            end
            fdcbf_pkg::S_COL: begin
                if (i_sts.out_free && i_sts.last_col) n_state = fdcbf_pkg::S_EOF;
            end
            fdcbf_pkg::S_EOF: begin
                if (i_sts.out_free) n_state = fdcbf_pkg::S_IDLE;
            end
            default: n_state = fdcbf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.sel      = fdcbf_pkg::B_SOF;
        case (r_state)
            fdcbf_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.pix_we   = i_sts.in_valid && !i_sts.req_send;
                // prefetch column 0 while the header goes out
                o_cmd.rd_en    = i_sts.in_valid && i_sts.req_send;
                o_cmd.cnt_clr  = i_sts.in_valid && i_sts.req_send;
            end
            fdcbf_pkg::S_SOF: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.sel  = fdcbf_pkg::B_SOF;
            end
            fdcbf_pkg::S_CMD: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.sel  = fdcbf_pkg::B_CMD;
            end
            fdcbf_pkg::S_ADDR: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.sel  = fdcbf_pkg::B_ADDR;
            end
            fdcbf_pkg::S_COL: begin
                o_cmd.load    = i_sts.out_free;
                o_cmd.sel     = fdcbf_pkg::B_COL;
                o_cmd.cnt_inc = i_sts.out_free && !i_sts.last_col;
                o_cmd.rd_en   = i_sts.out_free && !i_sts.last_col;
            end
            fdcbf_pkg::S_EOF: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.sel  = fdcbf_pkg::B_EOF;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

/* rtl/fdcbf_dp.sv */
module fdcbf_dp #(
    parameter int COLUMNS = fdcbf_pkg::C_COLUMNS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fdcbf_pkg::t_cmd                    i_cmd,
    output fdcbf_pkg::t_sts                    o_sts,
    input  logic                               i_in_valid,
    input  logic                               i_req_type,
    input  logic [7:0]                         i_pixel_x,
    input  logic [7:0]                         i_pixel_y,
    input  logic                               i_pixel_on,
    input  logic [fdcbf_pkg::C_WIDTH_W-1:0]    i_width,
    input  logic [fdcbf_pkg::C_HEIGHT_W-1:0]   i_height,
    input  logic                               i_invert,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [fdcbf_pkg::C_BYTE_W-1:0]     o_tx_byte,
    output logic                               o_frame_end
);

    localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam logic [AW-1:0] LAST_COL = AW'(COLUMNS - 1);
    localparam logic [6:0]    COLS_7   = 7'(COLUMNS);

    logic [fdcbf_pkg::C_WORD_W-1:0] r_mem [COLUMNS];
    logic [COLUMNS-1:0]             r_vld;

    logic [AW-1:0]                  r_cnt;
    logic [fdcbf_pkg::C_WORD_W-1:0] r_rd_word;
    logic                           r_rd_vld;
    logic                           r_out_valid;
    logic [fdcbf_pkg::C_BYTE_W-1:0] r_out_byte;
    logic                           r_out_end;

    logic                           hit;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [2:0]                     wr_row;
    logic [AW-1:0]                  rd_addr;
    logic                           out_free;
    logic [fdcbf_pkg::C_WORD_W-1:0] col_word;
    logic [fdcbf_pkg::C_BYTE_W-1:0] n_out_byte;

    // pixel clipping: non-negative and inside both configured and physical limits
    assign hit = !i_pixel_x[7] && !i_pixel_y[7]
              && (i_pixel_x[6:0] < {2'b00, i_width})
              && (i_pixel_x[6:0] < COLS_7)
              && (i_pixel_y[6:0] < {4'b0000, i_height});

    assign wr_en   = i_cmd.pix_we && hit;
    assign wr_addr = i_pixel_x[AW-1:0];
    assign wr_row  = i_pixel_y[2:0];

    // column store; a column not yet written takes zeros in its other rows
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int b = 0; b < fdcbf_pkg::C_WORD_W; b++) begin
                if (!r_vld[wr_addr] || (wr_row == 3'(b))) begin
                    r_mem[wr_addr][b] <= (wr_row == 3'(b)) ? i_pixel_on : 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    assign rd_addr = i_cmd.cnt_clr ? '0 : r_cnt + AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_word <= r_mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + AW'(1);
        end
    end

    assign col_word = (r_rd_vld ? r_rd_word : '0) ^ (i_invert ? fdcbf_pkg::C_INV_MASK : '0);

    always_comb begin
        case (i_cmd.sel)
            fdcbf_pkg::B_SOF:  n_out_byte = fdcbf_pkg::C_BYTE_SOF;
            fdcbf_pkg::B_CMD:  n_out_byte = fdcbf_pkg::C_BYTE_CMD;
            fdcbf_pkg::B_ADDR: n_out_byte = fdcbf_pkg::C_BYTE_ADDR;
            fdcbf_pkg::B_COL:  n_out_byte = {1'b0, col_word};
            fdcbf_pkg::B_EOF:  n_out_byte = fdcbf_pkg::C_BYTE_EOF;
            default:           n_out_byte = fdcbf_pkg::C_BYTE_EOF;
        endcase
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_byte <= n_out_byte;
            r_out_end  <= (i_cmd.sel == fdcbf_pkg::B_EOF);
        end
    end

    assign o_sts.in_valid = i_in_valid;
    assign o_sts.req_send = (i_req_type == fdcbf_pkg::C_REQ_SEND);
    assign o_sts.out_free = out_free;
    assign o_sts.last_col = (r_cnt == LAST_COL);

    assign o_out_valid = r_out_valid;
    assign o_tx_byte   = r_out_byte;
    assign o_frame_end = r_out_end;

endmodule
